>>> hdl/vara_pkg.sv
// Shared types, widths and tables of the vertex axis rotation unit.
package vara_pkg;

  localparam int COORD_WIDTH  = 16;
  localparam int ANGLE_WIDTH  = 16;
  localparam int CORDIC_STEPS = 30;
  localparam int STEP_IDX_W   = $clog2(CORDIC_STEPS);
  localparam int PHASE_W      = 32;                  // phase left-aligned to this width
  localparam int FRAC_W       = 30;                  // Q2.30 sine / cosine
  localparam int TRIG_W       = FRAC_W + 2;
  localparam int PROD_W       = COORD_WIDTH + TRIG_W;
  localparam int SUM_W        = PROD_W + 1;

  localparam int IN_FIELDS_W  = 3 * COORD_WIDTH + ANGLE_WIDTH;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 3 * COORD_WIDTH;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Gain-compensated 1.0 in Q2.30, start value of the CORDIC x path.
  localparam logic signed [TRIG_W-1:0] CORDIC_X0 = TRIG_W'(652032874);

  typedef enum logic [1:0] {
    AXIS_NONE = 2'd0,
    AXIS_X    = 2'd1,
    AXIS_Y    = 2'd2,
    AXIS_Z    = 2'd3
  } axis_t;

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] z;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] x;
  } vertex_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } trig_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] value;
    logic                          sat;
  } fin_t;

  // arctan(2^-i) as a fraction of a quarter turn, scaled by 2^30
  function automatic logic signed [TRIG_W-1:0] atan_lut(input logic [STEP_IDX_W-1:0] idx);
    logic signed [TRIG_W-1:0] a;
    case (idx)
      5'd0:  a = 32'sh20000000;
      5'd1:  a = 32'sh12E4051E;
      5'd2:  a = 32'sh09FB385B;
      5'd3:  a = 32'sh051111D4;
      5'd4:  a = 32'sh028B0D43;
      5'd5:  a = 32'sh0145D7E1;
      5'd6:  a = 32'sh00A2F61E;
      5'd7:  a = 32'sh00517C55;
      5'd8:  a = 32'sh0028BE53;
      5'd9:  a = 32'sh00145F2F;
      5'd10: a = 32'sh000A2F98;
      5'd11: a = 32'sh000517CC;
      5'd12: a = 32'sh00028BE6;
      5'd13: a = 32'sh000145F3;
      5'd14: a = 32'sh0000A2FA;
      5'd15: a = 32'sh0000517D;
      5'd16: a = 32'sh000028BE;
      5'd17: a = 32'sh0000145F;
      5'd18: a = 32'sh00000A30;
      5'd19: a = 32'sh00000518;
      5'd20: a = 32'sh0000028C;
      5'd21: a = 32'sh00000146;
      5'd22: a = 32'sh000000A3;
      5'd23: a = 32'sh00000051;
      5'd24: a = 32'sh00000029;
      5'd25: a = 32'sh00000014;
      5'd26: a = 32'sh0000000A;
      5'd27: a = 32'sh00000005;
      5'd28: a = 32'sh00000003;
      5'd29: a = 32'sh00000001;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> hdl/vara_cordic.sv
// Pipelined CORDIC sine / cosine with quadrant fold and clamp; carries the vertex along.
module vara_cordic
  import vara_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,       // whole pipe advances together
  input  logic                   vld_i,
  input  logic [ANGLE_WIDTH-1:0] phase_i,
  input  vertex_t                vtx_i,
  output logic                   vld_o,
  output trig_t                  trig_o,
  output vertex_t                vtx_o
);

  localparam logic signed [TRIG_W-1:0] ONE_Q30 = TRIG_W'(1) <<< FRAC_W;

  // stage 0 is the input register, stage k holds the result of step k-1
  logic signed [TRIG_W-1:0] x_r   [0:CORDIC_STEPS];
  logic signed [TRIG_W-1:0] y_r   [0:CORDIC_STEPS];
  logic signed [TRIG_W-1:0] z_r   [0:CORDIC_STEPS];
  logic signed [TRIG_W-1:0] x_nxt [0:CORDIC_STEPS];
  logic signed [TRIG_W-1:0] y_nxt [0:CORDIC_STEPS];
  logic signed [TRIG_W-1:0] z_nxt [0:CORDIC_STEPS];
  quad_t                    quad_r [0:CORDIC_STEPS];
  vertex_t                  vtx_r  [0:CORDIC_STEPS];
  logic [CORDIC_STEPS+1:0]  vld_r;

  logic [PHASE_W-1:0]       ph;
  logic signed [TRIG_W-1:0] c_sel, s_sel;
  trig_t                    trig_r, trig_nxt;
  vertex_t                  vtx_o_r;

  assign ph = {phase_i, {(PHASE_W - ANGLE_WIDTH){1'b0}}};

  always_comb begin
    x_nxt[0] = CORDIC_X0;
    y_nxt[0] = '0;
    z_nxt[0] = TRIG_W'(ph[FRAC_W-1:0]);
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      if (!z_r[k][TRIG_W-1]) begin
        x_nxt[k+1] = x_r[k] - (y_r[k] >>> k);
        y_nxt[k+1] = y_r[k] + (x_r[k] >>> k);
        z_nxt[k+1] = z_r[k] - atan_lut(STEP_IDX_W'(k));
      end else begin
        x_nxt[k+1] = x_r[k] + (y_r[k] >>> k);
        y_nxt[k+1] = y_r[k] - (x_r[k] >>> k);
        z_nxt[k+1] = z_r[k] + atan_lut(STEP_IDX_W'(k));
      end
    end
  end

  // quadrant fold, then clamp to +-1.0
  always_comb begin
    case (quad_r[CORDIC_STEPS])
      QUAD_I: begin
        c_sel = x_r[CORDIC_STEPS];
        s_sel = y_r[CORDIC_STEPS];
      end
      QUAD_II: begin
        c_sel = -y_r[CORDIC_STEPS];
        s_sel = x_r[CORDIC_STEPS];
      end
      QUAD_III: begin
        c_sel = -x_r[CORDIC_STEPS];
        s_sel = -y_r[CORDIC_STEPS];
      end
      default: begin
        c_sel = y_r[CORDIC_STEPS];
        s_sel = -x_r[CORDIC_STEPS];
      end
    endcase
    trig_nxt.cos_v = (c_sel > ONE_Q30) ? ONE_Q30 : ((c_sel < -ONE_Q30) ? -ONE_Q30 : c_sel);
    trig_nxt.sin_v = (s_sel > ONE_Q30) ? ONE_Q30 : ((s_sel < -ONE_Q30) ? -ONE_Q30 : s_sel);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= CORDIC_STEPS; k++) begin
        x_r[k] <= x_nxt[k];
        y_r[k] <= y_nxt[k];
        z_r[k] <= z_nxt[k];
      end
      quad_r[0] <= quad_t'(ph[PHASE_W-1:FRAC_W]);
      vtx_r[0]  <= vtx_i;
      for (int k = 1; k <= CORDIC_STEPS; k++) begin
        quad_r[k] <= quad_r[k-1];
        vtx_r[k]  <= vtx_r[k-1];
      end
      trig_r  <= trig_nxt;
      vtx_o_r <= vtx_r[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[CORDIC_STEPS:0], vld_i};
    end
  end

  assign vld_o  = vld_r[CORDIC_STEPS+1];
  assign trig_o = trig_r;
  assign vtx_o  = vtx_o_r;

endmodule

>>> hdl/vertex_axis_rotation_unit.sv
// Top level: rotates a Q2.14 vertex about the configured axis by a binary-phase angle.
// Takes one vertex per clock while in_tready is high and returns one rotated vertex
// per input beat, in order. An input beat is one vertex and its angle; the result beat
// passes through 34 pipeline registers (input register, 30 CORDIC steps, trig
// fold/clamp, products, output register), the first loaded at the accepting edge and
// the last driving the output. The sine / cosine come from a 30-step CORDIC with one
// step per stage. The whole pipe moves on one enable: it advances whenever
// the output register is empty or its beat is taken, and in_tready is that enable.
// axis_select (cfg_wr_data) picks 0 pass-through, 1 X, 2 Y, 3 Z; write it only
// while no beats are in flight. Rotated coordinates are rounded to nearest and
// saturated; out_tuser flags any clipping, pass-through coordinates never clip.
module vertex_axis_rotation_unit
  import vara_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // config
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_wr_data,   // axis_select
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,      // coord_x, coord_y, coord_z, angle_phase
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,     // rot_x, rot_y, rot_z
  output logic                  out_tuser      // saturated
);

  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [SUM_W-1:0] SUM_MAX  = (SUM_W'(1) <<< (COORD_WIDTH - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SUM_MIN  = -SUM_MAX - SUM_W'(1);
  localparam logic [COORD_WIDTH-1:0]  CRD_MAX  = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0]  CRD_MIN  = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  function automatic fin_t finish(input logic signed [SUM_W-1:0] acc);
    logic signed [SUM_W-1:0] v;
    fin_t r;
    v = (acc + RND_HALF) >>> FRAC_W;
    if (v > SUM_MAX) begin
      r.value = SUM_MAX[COORD_WIDTH-1:0];
      r.sat   = 1'b1;
    end else if (v < SUM_MIN) begin
      r.value = SUM_MIN[COORD_WIDTH-1:0];
      r.sat   = 1'b1;
    end else begin
      r.value = v[COORD_WIDTH-1:0];
      r.sat   = 1'b0;
    end
    return r;
  endfunction

  axis_t   axis_r;
  logic    en;
  vertex_t vtx_in;
  logic    trig_vld;
  trig_t   trig;
  vertex_t trig_vtx;

  // product stage
  logic signed [COORD_WIDTH-1:0] op_a, op_b;
  logic signed [PROD_W-1:0]      ac_r, bs_r, as_r, bc_r;
  vertex_t                       prod_vtx_r;
  logic                          prod_vld_r;

  // output stage
  logic signed [SUM_W-1:0]       sum1, sum2;
  fin_t                          fin1, fin2;
  vertex_t                       res_nxt;
  logic                          sat_nxt;
  logic                          out_vld_r;
  vertex_t                       out_vtx_r;
  logic                          out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= AXIS_NONE;
    end else if (cfg_wr_en) begin
      axis_r <= axis_t'(cfg_wr_data);
    end
  end

  // pipe enable: output register free or being drained
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  assign vtx_in.x = in_tdata[COORD_WIDTH-1:0];
  assign vtx_in.y = in_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
  assign vtx_in.z = in_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];

  vara_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (in_tvalid),
    .phase_i (in_tdata[IN_FIELDS_W-1:3*COORD_WIDTH]),
    .vtx_i   (vtx_in),
    .vld_o   (trig_vld),
    .trig_o  (trig),
    .vtx_o   (trig_vtx)
  );

  // Every axis reduces to out1 = a*c - b*s, out2 = a*s + b*c
  //   X: a=y b=z -> (ry, rz)   Y: a=z b=x -> (rz, rx)   Z: a=x b=y -> (rx, ry)
  always_comb begin
    case (axis_r)
      AXIS_X: begin
        op_a = trig_vtx.y;
        op_b = trig_vtx.z;
      end
      AXIS_Y: begin
        op_a = trig_vtx.z;
        op_b = trig_vtx.x;
      end
      default: begin
        op_a = trig_vtx.x;
        op_b = trig_vtx.y;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ac_r       <= PROD_W'(op_a) * PROD_W'(trig.cos_v);
      bs_r       <= PROD_W'(op_b) * PROD_W'(trig.sin_v);
      as_r       <= PROD_W'(op_a) * PROD_W'(trig.sin_v);
      bc_r       <= PROD_W'(op_b) * PROD_W'(trig.cos_v);
      prod_vtx_r <= trig_vtx;
    end
  end

  always_comb begin
    sum1    = SUM_W'(ac_r) - SUM_W'(bs_r);
    sum2    = SUM_W'(as_r) + SUM_W'(bc_r);
    fin1    = finish(sum1);
    fin2    = finish(sum2);
    res_nxt = prod_vtx_r;
    sat_nxt = fin1.sat | fin2.sat;
    case (axis_r)
      AXIS_X: begin
        res_nxt.y = fin1.value;
        res_nxt.z = fin2.value;
      end
      AXIS_Y: begin
        res_nxt.z = fin1.value;
        res_nxt.x = fin2.value;
      end
      AXIS_Z: begin
        res_nxt.x = fin1.value;
        res_nxt.y = fin2.value;
      end
      default: begin
        sat_nxt = 1'b0;   // pass-through
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vtx_r <= res_nxt;
      out_sat_r <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else if (en) begin
      prod_vld_r <= trig_vld;
      out_vld_r  <= prod_vld_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_DATA_W'({out_vtx_r.z, out_vtx_r.y, out_vtx_r.x});
  assign out_tuser  = out_sat_r;

`ifndef SYNTH
  // pass-through mode never reports clipping
  a_none_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && axis_r == AXIS_NONE) |-> !out_tuser)
    else $error("saturated flag set in pass-through mode");

  // a clipped beat carries at least one coordinate at a range limit
  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      (out_vtx_r.x == CRD_MAX || out_vtx_r.x == CRD_MIN ||
       out_vtx_r.y == CRD_MAX || out_vtx_r.y == CRD_MIN ||
       out_vtx_r.z == CRD_MAX || out_vtx_r.z == CRD_MIN))
    else $error("saturated flag without a coordinate at its limit");

  // a stalled pipe does not let a result slip into the output register
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |=> (out_vld_r && $stable(out_vtx_r) && $stable(out_sat_r)))
    else $error("output register changed while stalled");
`endif

endmodule
